>>> sv/tei_pkg.sv
// tei_pkg: shared codes, widths and the quarter-wave sine table of the easing interpolator
// no dependencies; used by timed_easing_interpolator
`timescale 1ns / 1ps
`default_nettype none

package tei_pkg;

    // command codes of an input item
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_START_VALUE = 2'd0;
    localparam logic [1:0] REG_END_VALUE   = 2'd1;
    localparam logic [1:0] REG_DURATION    = 2'd2;
    localparam logic [1:0] REG_EASING_MODE = 2'd3;

    // easing curves
    localparam logic [2:0] EASE_IN_QUAD     = 3'd1;
    localparam logic [2:0] EASE_OUT_QUAD    = 3'd2;
    localparam logic [2:0] EASE_INOUT_QUAD  = 3'd3;
    localparam logic [2:0] EASE_OUT_BOUNCE  = 3'd4;
    localparam logic [2:0] EASE_OUT_ELASTIC = 3'd5;

    localparam int unsigned ONE_Q16 = 65536;
    localparam int unsigned LN2_Q16 = 45426;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // quarter-wave table of SINE_N + 1 entries, SINE_N a power of two
    localparam int SINE_LOG2 = 8;
    localparam int SINE_N    = 1 << SINE_LOG2;
    localparam int IDX_W     = SINE_LOG2 + 2;
    // phase = floor((100T + 98304) * 4N / 196608) = floor(((100T + 98304) >> PH_SHIFT) / 3)
    localparam int PH_SHIFT  = 14 - SINE_LOG2;

    typedef logic [16:0] t_sine_tab [0:SINE_N];

    // long division for the table build
    function automatic longint unsigned f_udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // taylor series of sin in Q30, rounded to Q16
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab tab;
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint q;
        for (int i = 0; i <= SINE_N; i++) begin
            // scale by 1 / (2N)
            x = (PI_Q30 * longint'(i)) >> (SINE_LOG2 + 1);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x) >> 30) * x >> 30;
                term = f_udiv(term, longint'((2 * k) * (2 * k + 1)));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (sum + 8192) >>> 14;
            if (q > 65536) begin
                q = 65536;
            end
            tab[i] = q[16:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

endpackage

`default_nettype wire

>>> sv/timed_easing_interpolator.sv
// timed_easing_interpolator: command sequencer with a bit-serial divider and multiplier
// depends on tei_pkg for codes and the sine table
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Input channel i_valid/o_ready carries one item: i_operation (update, start, reset)
// and i_current_time. Each item gives exactly one result on o_valid/i_ready:
// o_value (Q16.16), o_done_res and o_running.
// Start, reset and unused items, and updates that end early (idle, finished, before
// the start time, at or past the duration), go straight to the put state, which
// loads the output register when it is free and returns to idle (o_ready high).
// An update that eases runs a restoring divider one quotient bit per cycle
// (16 quotient bits for t) and a shift-add multiplier one bit per cycle (20
// multiplier bits per product): linear and t of zero need only the final product,
// the quad curves and bounce one curve product more, elastic three divisions (16,
// 17 and 23 bits) and three products; each result then goes through the put state.
// One item is worked on at a time; o_ready is high while the sequencer is free,
// also while a finished result still waits in the output register.
// When the receiver stalls, the next result waits inside the sequencer until the
// output register empties, and no new item is taken meanwhile.
// Reset (synchronous, active low) clears the state, the config registers and o_valid.
// Configuration writes (i_cfg_we) take effect at once and do not touch o_value.
module timed_easing_interpolator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [1:0]   i_operation,
    input  wire logic [31:0]  i_current_time,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic signed [31:0] o_value,
    output logic              o_done_res,
    output logic              o_running,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIV_T, S_SETUP, S_MUL_EASE, S_EASE_DONE, S_LN_MUL, S_RECIP,
        S_RECIP_DIV, S_PHASE, S_PHASE_DIV, S_SINE, S_SIN_MUL, S_ELA_DONE,
        S_FIN_SETUP, S_FIN_MUL, S_FIN_Q, S_FIN_SUM, S_PUT
    } t_state;

    t_state r_state;

    logic signed [31:0] r_start_value;
    logic signed [31:0] r_end_value;
    logic [31:0]        r_duration;
    logic [2:0]         r_mode;

    logic               r_armed;
    logic               r_ended;
    logic [31:0]        r_begin;
    logic signed [31:0] r_present;

    // serial units
    logic [4:0]  r_cnt;
    logic [32:0] r_mc;
    logic [19:0] r_mp;
    logic [52:0] r_acc;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [22:0] r_dvd;
    logic [22:0] r_quo;

    // per item working values
    logic [15:0]        r_t;
    logic [17:0]        r_e;
    logic [15:0]        r_c;
    logic [3:0]         r_ip;
    logic [16:0]        r_p;
    logic               r_neg;
    logic signed [35:0] r_q;

    // multiplier step: add into the top, shift right
    logic [33:0] mul_sum;
    logic [52:0] n_acc;
    // divider step: shift one bit in, subtract if it fits
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [22:0] n_quo;

    // update checks
    logic [31:0] upd_elapsed;

    // bounce and elastic helpers
    logic [19:0]        t11;
    logic signed [20:0] bu;
    logic [18:0]        bu_mag;
    logic [15:0]        bc;
    logic [19:0]        t10;
    logic [22:0]        ph_x;
    logic [tei_pkg::IDX_W-1:0]   ph_idx;
    logic [tei_pkg::SINE_LOG2:0] sin_addr;
    logic [33:0]        ela_prod;
    logic [17:0]        ela_frac;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [50:0]        fin_prod;
    logic [34:0]        fin_up;
    logic signed [36:0] fin_sum;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        mul_sum  = {1'b0, r_acc[52:20]} + (r_mp[0] ? {1'b0, r_mc} : 34'd0);
        n_acc    = {mul_sum, r_acc[19:1]};
        div_t    = {r_rem, r_dvd[22]};
        div_ge   = (div_t >= {1'b0, r_dvs});
        div_diff = div_t - {1'b0, r_dvs};
        n_quo    = {r_quo[21:0], div_ge};

        upd_elapsed = i_current_time - r_begin;

        t11 = ({4'd0, r_t} << 3) + ({4'd0, r_t} << 1) + {4'd0, r_t};
        if (t11 < 20'd262144) begin
            bu = signed'({1'b0, t11});
            bc = 16'd0;
        end else if (t11 < 20'd524288) begin
            bu = signed'({1'b0, t11}) - 21'sd393216;
            bc = 16'd49152;
        end else if (t11 < 20'd655360) begin
            bu = signed'({1'b0, t11}) - 21'sd589824;
            bc = 16'd61440;
        end else begin
            bu = signed'({1'b0, t11}) - 21'sd688128;
            bc = 16'd64512;
        end
        bu_mag = bu[20] ? 19'(-bu) : bu[18:0];

        t10  = ({4'd0, r_t} << 3) + ({4'd0, r_t} << 1);
        ph_x = ({7'd0, r_t} << 6) + ({7'd0, r_t} << 5) + ({7'd0, r_t} << 2) + 23'd98304;

        ph_idx = r_quo[tei_pkg::IDX_W-1:0];
        if (ph_idx[tei_pkg::SINE_LOG2]) begin
            sin_addr = (tei_pkg::SINE_LOG2 + 1)'(tei_pkg::SINE_N)
                       - {1'b0, ph_idx[tei_pkg::SINE_LOG2-1:0]};
        end else begin
            sin_addr = {1'b0, ph_idx[tei_pkg::SINE_LOG2-1:0]};
        end

        // floor of signed product over 2^16, plus one
        ela_prod = r_acc[33:0];
        if (r_neg) begin
            ela_frac = 18'(tei_pkg::ONE_Q16) - 18'((ela_prod + 34'd65535) >> 16);
        end else begin
            ela_frac = 18'(tei_pkg::ONE_Q16) + 18'(ela_prod >> 16);
        end

        diff     = 33'(r_end_value) - 33'(r_start_value);
        diff_mag = diff[32] ? 33'(-diff) : diff;

        fin_prod = r_acc[50:0];
        fin_up   = 35'((fin_prod + 51'd65535) >> 16);
        fin_sum  = 37'(r_start_value) + 37'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_value <= '0;
            r_end_value   <= '0;
            r_duration    <= '0;
            r_mode        <= '0;
            r_armed       <= 1'b0;
            r_ended       <= 1'b0;
            r_begin       <= '0;
            r_present     <= '0;
            r_cnt         <= '0;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tei_pkg::REG_START_VALUE: r_start_value <= signed'(i_cfg_data);
                    tei_pkg::REG_END_VALUE:   r_end_value   <= signed'(i_cfg_data);
                    tei_pkg::REG_DURATION:    r_duration    <= i_cfg_data;
                    tei_pkg::REG_EASING_MODE: r_mode        <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            // the put state reloads the output itself
            if (o_valid && i_ready && r_state != S_PUT) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_PUT;
                        unique case (i_operation)
                            tei_pkg::OP_START: begin
                                r_begin   <= i_current_time;
                                r_armed   <= 1'b1;
                                r_ended   <= 1'b0;
                                r_present <= r_start_value;
                            end
                            tei_pkg::OP_RESET: begin
                                r_armed   <= 1'b0;
                                r_ended   <= 1'b0;
                                r_present <= r_start_value;
                            end
                            tei_pkg::OP_UPDATE: begin
                                if (r_armed && !r_ended) begin
                                    if (i_current_time < r_begin) begin
                                        r_present <= r_start_value;
                                    end else if (upd_elapsed >= r_duration) begin
                                        r_present <= r_end_value;
                                        r_ended   <= 1'b1;
                                    end else begin
                                        r_rem   <= upd_elapsed;
                                        r_dvs   <= r_duration;
                                        r_dvd   <= '0;
                                        r_quo   <= '0;
                                        r_cnt   <= 5'd15;
                                        r_state <= S_DIV_T;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_DIV_T, S_RECIP_DIV, S_PHASE_DIV: begin
                    r_rem <= div_ge ? div_diff[31:0] : div_t[31:0];
                    r_dvd <= {r_dvd[21:0], 1'b0};
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        if (r_state == S_DIV_T) begin
                            r_state <= S_SETUP;
                        end else if (r_state == S_RECIP_DIV) begin
                            r_state <= S_PHASE;
                        end else begin
                            r_state <= S_SINE;
                        end
                    end
                end

                S_SETUP: begin
                    r_t   <= r_quo[15:0];
                    r_acc <= '0;
                    r_mp  <= {4'd0, r_quo[15:0]};
                    if (r_quo[15:0] == 16'd0) begin
                        r_e     <= '0;
                        r_state <= S_FIN_SETUP;
                    end else begin
                        // r_t is not loaded yet, so the curve setup uses r_quo
                        case (r_mode)
                            tei_pkg::EASE_IN_QUAD: begin
                                r_mc    <= {17'd0, r_quo[15:0]};
                                r_cnt   <= 5'd19;
                                r_state <= S_MUL_EASE;
                            end
                            tei_pkg::EASE_OUT_QUAD: begin
                                r_mc    <= 33'd131072 - {17'd0, r_quo[15:0]};
                                r_cnt   <= 5'd19;
                                r_state <= S_MUL_EASE;
                            end
                            tei_pkg::EASE_INOUT_QUAD: begin
                                if (!r_quo[15]) begin
                                    r_mc <= {16'd0, r_quo[15:0], 1'b0};
                                end else begin
                                    r_mc <= 33'd262144 - {16'd0, r_quo[15:0], 1'b0};
                                end
                                r_cnt   <= 5'd19;
                                r_state <= S_MUL_EASE;
                            end
                            tei_pkg::EASE_OUT_BOUNCE, tei_pkg::EASE_OUT_ELASTIC: begin
                                // needs 11t or 10t first
                                r_cnt   <= 5'd31;
                                r_state <= S_RECIP;
                            end
                            default: begin
                                r_e     <= {2'd0, r_quo[15:0]};
                                r_state <= S_FIN_SETUP;
                            end
                        endcase
                    end
                end

                S_MUL_EASE, S_LN_MUL, S_SIN_MUL, S_FIN_MUL: begin
                    r_acc <= n_acc;
                    r_mp  <= {1'b0, r_mp[19:1]};
                    if (r_cnt == 5'd0) begin
                        // count stays at zero so the reciprocal step divides next
                        case (r_state)
                            S_MUL_EASE: r_state <= S_EASE_DONE;
                            S_LN_MUL:   r_state <= S_RECIP;
                            S_SIN_MUL:  r_state <= S_ELA_DONE;
                            default:    r_state <= S_FIN_Q;
                        endcase
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end

                S_EASE_DONE: begin
                    r_state <= S_FIN_SETUP;
                    case (r_mode)
                        tei_pkg::EASE_INOUT_QUAD: begin
                            if (!r_t[15]) begin
                                r_e <= r_acc[33:16];
                            end else begin
                                r_e <= r_acc[33:16] - 18'(tei_pkg::ONE_Q16);
                            end
                        end
                        tei_pkg::EASE_OUT_BOUNCE: r_e <= r_acc[37:20] + {2'd0, r_c};
                        default: r_e <= r_acc[33:16];
                    endcase
                end

                S_RECIP: begin
                    if (r_cnt == 5'd31) begin
                        // entry from setup: start the curve product
                        r_acc <= '0;
                        r_cnt <= 5'd19;
                        if (r_mode == tei_pkg::EASE_OUT_BOUNCE) begin
                            r_mc    <= {14'd0, bu_mag};
                            r_mp    <= {1'b0, bu_mag};
                            r_c     <= bc;
                            r_state <= S_MUL_EASE;
                        end else begin
                            r_ip    <= t10[19:16];
                            r_mc    <= 33'(tei_pkg::LN2_Q16);
                            r_mp    <= {4'd0, t10[15:0]};
                            r_state <= S_LN_MUL;
                        end
                    end else begin
                        // 2^32 / m, starting from 2^15 with 17 quotient bits
                        r_dvs   <= {15'd0, 17'(tei_pkg::ONE_Q16) + {1'b0, r_acc[31:16]}};
                        r_rem   <= 32'd32768;
                        r_dvd   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 5'd16;
                        r_state <= S_RECIP_DIV;
                    end
                end

                S_PHASE: begin
                    r_p     <= r_quo[16:0] >> r_ip;
                    r_rem   <= '0;
                    r_dvs   <= 32'd3;
                    r_dvd   <= ph_x >> tei_pkg::PH_SHIFT;
                    r_quo   <= '0;
                    r_cnt   <= 5'd22;
                    r_state <= S_PHASE_DIV;
                end

                S_SINE: begin
                    r_mc    <= {16'd0, r_p};
                    r_mp    <= {3'd0, tei_pkg::SINE_TAB[sin_addr]};
                    r_neg   <= ph_idx[tei_pkg::SINE_LOG2+1];
                    r_acc   <= '0;
                    r_cnt   <= 5'd19;
                    r_state <= S_SIN_MUL;
                end

                S_ELA_DONE: begin
                    r_e     <= ela_frac;
                    r_state <= S_FIN_SETUP;
                end

                S_FIN_SETUP: begin
                    r_mc    <= diff_mag;
                    r_mp    <= {2'd0, r_e};
                    r_neg   <= diff[32];
                    r_acc   <= '0;
                    r_cnt   <= 5'd19;
                    r_state <= S_FIN_MUL;
                end

                S_FIN_Q: begin
                    if (r_neg) begin
                        r_q <= -signed'({1'b0, fin_up});
                    end else begin
                        r_q <= signed'({1'b0, fin_prod[50:16]});
                    end
                    r_state <= S_FIN_SUM;
                end

                S_FIN_SUM: begin
                    if (fin_sum > 37'sd2147483647) begin
                        r_present <= 32'sh7FFFFFFF;
                    end else if (fin_sum < -37'sd2147483648) begin
                        r_present <= 32'sh80000000;
                    end else begin
                        r_present <= fin_sum[31:0];
                    end
                    r_state <= S_PUT;
                end

                S_PUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_value    <= r_present;
                        o_done_res <= r_ended;
                        o_running  <= r_armed;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_timed_easing_interpolator.sv
// tb_timed_easing_interpolator: random and directed test of the easing interpolator
// depends on tei_pkg and timed_easing_interpolator; expected values come from an in-bench predictor
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic signed [31:0] value;
    logic               done_res;
    logic               running;
} t_ease_result;

class easing_scoreboard;
    longint          start_v;
    longint          end_v;
    longint unsigned dur_ticks;
    logic [2:0]      mode;
    bit              armed;
    bit              ended;
    longint unsigned t_begin;
    longint          cur_value;
    longint          quarter [0:tei_pkg::SINE_N];
    t_ease_result    pending [$];
    int              errors;
    int              checked;
    int              n_ended;
    int              n_sat;

    function new();
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint q;
        for (int i = 0; i <= tei_pkg::SINE_N; i++) begin
            x = tei_pkg::PI_Q30 * longint'(i) / longint'(2 * tei_pkg::SINE_N);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x) >> 30) * x >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            q = (sum + 8192) >>> 14;
            quarter[i] = (q > 65536) ? 65536 : q;
        end
        start_v = 0; end_v = 0; dur_ticks = 0; mode = 0;
        armed = 0; ended = 0; t_begin = 0; cur_value = 0;
        errors = 0; checked = 0; n_ended = 0; n_sat = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            tei_pkg::REG_START_VALUE: start_v = longint'(signed'(data));
            tei_pkg::REG_END_VALUE:   end_v = longint'(signed'(data));
            tei_pkg::REG_DURATION:    dur_ticks = longint'(data);
            tei_pkg::REG_EASING_MODE: mode = data[2:0];
            default: ;
        endcase
    endfunction

    function longint sine_lookup(longint t);
        longint n;
        longint idx;
        longint r;
        n = (100 * t - 491520) * (4 * tei_pkg::SINE_N) + 3 * 196608 * (4 * tei_pkg::SINE_N);
        idx = (n / 196608) % (4 * tei_pkg::SINE_N);
        r = idx % tei_pkg::SINE_N;
        case (idx / tei_pkg::SINE_N)
            0: return quarter[r];
            1: return quarter[tei_pkg::SINE_N - r];
            2: return -quarter[r];
            default: return -quarter[tei_pkg::SINE_N - r];
        endcase
    endfunction

    function longint bounce_curve(longint t);
        longint e;
        longint u;
        longint c;
        e = 11 * t;
        if (e < 4 * 65536) begin
            u = e; c = 0;
        end else if (e < 8 * 65536) begin
            u = e - 6 * 65536; c = 49152;
        end else if (e < 10 * 65536) begin
            u = e - 9 * 65536; c = 61440;
        end else begin
            u = e - 688128; c = 64512;
        end
        return ((u * u) >> 20) + c;
    endfunction

    function longint elastic_curve(longint t);
        longint unsigned e10;
        longint unsigned frac;
        longint unsigned m;
        longint p;
        e10 = 10 * t;
        frac = e10 & 64'hFFFF;
        m = 65536 + ((frac * tei_pkg::LN2_Q16) >> 16);
        p = longint'(((64'd1 << 32) / m) >> (e10 >> 16));
        return ((p * sine_lookup(t)) >>> 16) + 65536;
    endfunction

    function longint shape(longint t);
        if (t <= 0) return 0;
        case (mode)
            tei_pkg::EASE_IN_QUAD:     return (t * t) >> 16;
            tei_pkg::EASE_OUT_QUAD:    return (t * (131072 - t)) >> 16;
            tei_pkg::EASE_INOUT_QUAD:  return (t < 32768) ? (2 * t * t) >> 16
                                                 : -65536 + (((262144 - 2 * t) * t) >> 16);
            tei_pkg::EASE_OUT_BOUNCE:  return bounce_curve(t);
            tei_pkg::EASE_OUT_ELASTIC: return elastic_curve(t);
            default:                   return t;
        endcase
    endfunction

    function void advance(longint unsigned now);
        longint unsigned elapsed;
        longint t;
        longint v;
        if (!armed || ended) return;
        if (now < t_begin) begin
            cur_value = start_v;
            return;
        end
        elapsed = now - t_begin;
        if (elapsed >= dur_ticks) begin
            cur_value = end_v;
            ended = 1;
            n_ended++;
        end else begin
            t = longint'((elapsed << 16) / dur_ticks);
            v = start_v + (((end_v - start_v) * shape(t)) >>> 16);
            if (v > 64'sd2147483647 || v < -64'sd2147483648) n_sat++;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            cur_value = v;
        end
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] now);
        t_ease_result r;
        case (op)
            tei_pkg::OP_START: begin
                t_begin = longint'(now); armed = 1; ended = 0; cur_value = start_v;
            end
            tei_pkg::OP_RESET: begin
                armed = 0; ended = 0; cur_value = start_v;
            end
            tei_pkg::OP_UPDATE: advance(longint'(now));
            default: ;
        endcase
        r.value = cur_value[31:0];
        r.done_res = ended;
        r.running = armed;
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] value, logic done_res, logic running);
        t_ease_result r;
        if (pending.size() == 0) begin
            $error("result with nothing expected: value %0d", value);
            errors++;
            return;
        end
        r = pending.pop_front();
        checked++;
        if (value !== r.value) begin
            $error("value: expected %0d, got %0d", r.value, value);
            errors++;
        end
        if (done_res !== r.done_res) begin
            $error("done_res: expected %0b, got %0b", r.done_res, done_res);
            errors++;
        end
        if (running !== r.running) begin
            $error("running: expected %0b, got %0b", r.running, running);
            errors++;
        end
    endfunction
endclass

module tb_timed_easing_interpolator;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int ITEM_TARGET = 1850;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [1:0] i_operation = tei_pkg::OP_UPDATE;
    logic [31:0] i_current_time = 0;
    logic o_valid;
    logic i_ready = 0;
    logic signed [31:0] o_value;
    logic o_done_res;
    logic o_running;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_idx = tei_pkg::REG_START_VALUE;
    logic [31:0] i_cfg_data = 0;

    easing_scoreboard sb = new();
    int items_in = 0;
    int gap_pct = 6;
    int stall_pct = 54;
    longint cycles = 0;

    timed_easing_interpolator uut (.*);

    always #5 i_clk = ~i_clk;

    // sample both handshakes on the rising edge, before the block updates
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) begin
            sb.note_item(i_operation, i_current_time);
            items_in <= items_in + 1;
        end
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_value, o_done_res, o_running);
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) i_ready = ($urandom_range(99) >= stall_pct);

    task automatic send_item(logic [1:0] op, logic [31:0] now);
        int seen;
        while ($urandom_range(99) < gap_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        seen = items_in;
        i_valid = 1;
        i_operation = op;
        i_current_time = now;
        do @(negedge i_clk); while (items_in == seen);
        if (items_in >= ITEM_TARGET / 3) begin
            gap_pct = 54; stall_pct = 6;
        end
        if (items_in >= 2 * ITEM_TARGET / 3) begin
            gap_pct = 0; stall_pct = 0;
        end
    endtask

    task automatic drain();
        i_valid = 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_all(logic [31:0] sv, logic [31:0] ev, logic [31:0] d, logic [2:0] m);
        write_reg(tei_pkg::REG_START_VALUE, sv);
        write_reg(tei_pkg::REG_END_VALUE, ev);
        write_reg(tei_pkg::REG_DURATION, d);
        write_reg(tei_pkg::REG_EASING_MODE, {29'd0, m});
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom;
            default: return $urandom_range(2, 5000);
        endcase
    endfunction

    // one animation: start, a mostly rising series of updates, some noise
    task automatic run_animation();
        logic [31:0] t0;
        logic [31:0] now;
        longint unsigned span;
        int len;
        t0 = $urandom;
        span = longint'(sb.dur_ticks) + longint'(sb.dur_ticks) / 8 + 2;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        len = $urandom_range(8, 30);
        send_item(tei_pkg::OP_START, t0);
        for (int k = 0; k < len; k++) begin
            now = t0 + 32'(longint'(span) * k / len + $urandom_range(0, 3));
            case ($urandom_range(19))
                0: send_item(tei_pkg::OP_UPDATE, t0 - $urandom_range(1, 1000));
                1: send_item(tei_pkg::OP_RESET, $urandom);
                2: send_item(OP_IGNORED, $urandom);
                3: send_item(tei_pkg::OP_START, t0);
                4: send_item(tei_pkg::OP_UPDATE, $urandom);
                default: send_item(tei_pkg::OP_UPDATE, now);
            endcase
        end
        send_item(tei_pkg::OP_UPDATE, t0 + 32'(span));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // idle block: an update, an unused code and a reset leave everything as it is
        send_item(tei_pkg::OP_UPDATE, 32'hFFFF_FFFF);
        send_item(OP_IGNORED, 0);
        send_item(tei_pkg::OP_RESET, 0);
        drain();
        // an update before the start gives the start value; zero duration finishes on the first update at or after it
        set_all(32'h0001_0000, 32'hFFFF_0000, 0, 3'd0);
        send_item(tei_pkg::OP_START, 32'h0000_0010);
        send_item(tei_pkg::OP_UPDATE, 32'h0000_000F);
        send_item(tei_pkg::OP_UPDATE, 32'h0000_0010);
        send_item(tei_pkg::OP_UPDATE, 32'h0000_0020);
        drain();
        // every mode on a full-range swing: elastic overshoot saturates; six and seven are unused and run linear
        for (int m = 0; m < 8; m++) begin
            set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'd1000, m[2:0]);
            send_item(tei_pkg::OP_START, 32'hFFFF_FF00);
            for (int k = 1; k < 4; k++) begin
                send_item(tei_pkg::OP_UPDATE, 32'hFFFF_FF00 + 32'(k * 230));
            end
            send_item(tei_pkg::OP_UPDATE, 32'hFFFF_FFFF);
            drain();
        end

        while (items_in < ITEM_TARGET) begin
            set_all(pick_value(), pick_value(), pick_duration(), 3'($urandom_range(7)));
            run_animation();
            drain();
        end

        $display("checked %0d results over %0d items; %0d finished animations, %0d saturations",
                 sb.checked, items_in, sb.n_ended, sb.n_sat);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> timed_easing_interpolator.f
sv/tei_pkg.sv
sv/timed_easing_interpolator.sv
tb/tb_timed_easing_interpolator.sv
